/* rtl/core/scm_pkg.sv */
// Package of shared types, register codes and the controller state type.
package scm_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } scm_in_t;

    typedef struct packed {
        logic signed [23:0] shift;
        logic [7:0]         kept_count;
    } scm_out_t;

    localparam logic [0:0] REG_PASS_LIMIT = 1'b0;
    localparam logic [0:0] REG_CLIP_SIGMA = 1'b1;

    localparam logic [3:0] PASS_LIMIT_RST = 4'd10;
    localparam logic [3:0] CLIP_SIGMA_RST = 4'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SUM,
        ST_MUL_V,
        ST_MUL_T,
        ST_DIV,
        ST_CLIP,
        ST_D2,
        ST_CMP,
        ST_NEXT,
        ST_OUT
    } scm_state_t;

endpackage

/* rtl/core/scm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module scm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sigma_clipped_common_mode_core.sv */
// Top level: sample store, clipping sequencer, fixed-point mean and result register.
// Sequence: after the last beat, each pass sums the samples kept at pass start, does two
//   multiplies, runs a serial divider, and reads, measures and compares each sample to clip.
// Throughput: one sample beat per cycle while loading, also while a result waits;
//   no beat is taken while clipping, and the result waits while the output is full.
// Reset (aresetn, synchronous, active low) clears control; registers to 10 passes, 3 sigma.
module sigma_clipped_common_mode_core
    import scm_pkg::*;
#(
    parameter int MAX_SAMPLES = 128
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  scm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output scm_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    // sums: S up to CW+15 bits signed, Q up to CW+30 bits
    localparam int SW = CW + 17;
    localparam int QW = CW + 32;
    localparam int VW = CW + QW + 2;
    localparam int TW = VW + 8;
    localparam int DW = CW + 18;
    localparam int NW = SW + 8;

    logic [3:0] pass_limit_reg, clip_sigma_reg;
    scm_state_t state_reg, state_next;

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] ok_reg, ok_next;
    logic [3:0]    pass_reg, pass_next;
    logic          rvalid_reg, rvalid_next;

    logic signed [SW-1:0] s_reg, s_next;
    logic [QW-1:0]        q_reg, q_next;
    logic signed [VW-1:0] v_reg, v_next;
    logic [TW-1:0]        thr_reg, thr_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [23:0]   mean_reg, mean_next;
    logic signed [15:0]   x_reg, x_next;

    // serial divider for (S*256)/n
    logic [NW-1:0]   quo_reg, quo_next;
    logic [CW:0]     rem_reg, rem_next;
    logic [6:0]      dcnt_reg, dcnt_next;
    logic            neg_reg, neg_next;
    logic [CW+1:0]   trial;

    // squared deviation of the sample under test
    logic [TW-1:0]   d_sq;

    logic            m_valid_reg, m_valid_next;
    scm_out_t        m_data_reg, m_data_next;

    // RAM ports
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [15:0]     wdata, rdata;

    scm_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign trial = {rem_reg, quo_reg[NW-1]} - {2'b0, n_reg};
    assign d_sq  = TW'(d_reg * d_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_limit_reg <= PASS_LIMIT_RST;
            clip_sigma_reg <= CLIP_SIGMA_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PASS_LIMIT: pass_limit_reg <= cfg_data;
                REG_CLIP_SIGMA: clip_sigma_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:  if (s_valid && s_ready && s_data.last) begin
                state_next = ST_NEXT;
            end
            ST_NEXT:  state_next = (pass_reg >= pass_limit_reg || n_reg == '0) ? ST_OUT
                                                                              : ST_SUM;
            ST_SUM:   if (rvalid_reg && rd_reg == n_reg) begin
                state_next = ST_MUL_V;
            end
            ST_MUL_V: state_next = ST_MUL_T;
            ST_MUL_T: state_next = ST_DIV;
            ST_DIV:   if (dcnt_reg == '0) begin
                state_next = ST_CLIP;
            end
            ST_CLIP:  state_next = (rd_reg == n_reg) ? ST_NEXT : ST_D2;
            ST_D2:    state_next = ST_CMP;
            ST_CMP:   state_next = ST_CLIP;
            ST_OUT:   if (!m_valid_reg || m_ready) begin
                state_next = ST_LOAD;
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        fill_next    = fill_reg;
        n_next       = n_reg;
        rd_next      = rd_reg;
        ok_next      = ok_reg;
        pass_next    = pass_reg;
        rvalid_next  = 1'b0;
        s_next       = s_reg;
        q_next       = q_reg;
        v_next       = v_reg;
        thr_next     = thr_reg;
        d_next       = d_reg;
        mean_next    = mean_reg;
        x_next       = x_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        we           = 1'b0;
        waddr        = fill_reg[AW-1:0];
        wdata        = s_data.sample;
        raddr        = rd_reg[AW-1:0];
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_ready) begin
                    if (fill_reg < CW'(MAX_SAMPLES)) begin
                        we        = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    if (s_data.last) begin
                        n_next    = (fill_reg < CW'(MAX_SAMPLES)) ? fill_reg + 1'b1 : fill_reg;
                        pass_next = '0;
                        mean_next = '0;
                        rd_next   = '0;
                        s_next    = '0;
                        q_next    = '0;
                    end
                end
            end
            ST_NEXT: begin
                rd_next = '0;
                s_next  = '0;
                q_next  = '0;
            end
            ST_SUM: begin
                // one read per cycle, accumulate the previous one
                if (rd_reg != n_reg) begin
                    rd_next     = rd_reg + 1'b1;
                    rvalid_next = 1'b1;
                end
                if (rvalid_reg) begin
                    s_next = s_reg + SW'($signed(rdata));
                    q_next = q_reg + QW'($signed(rdata) * $signed(rdata));
                end
            end
            ST_MUL_V: begin
                v_next = VW'($signed({1'b0, n_reg}) * $signed({1'b0, q_reg}))
                         - VW'(s_reg * s_reg);
                neg_next  = s_reg < 0;
                quo_next  = NW'(s_reg < 0 ? -s_reg : s_reg) << 8;
                rem_next  = '0;
                dcnt_next = 7'(NW);
            end
            ST_MUL_T: begin
                thr_next = (v_reg < 0) ? '0
                         : TW'($unsigned(v_reg)) * TW'(clip_sigma_reg * clip_sigma_reg);
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (dcnt_reg != '0) begin
                    if (!trial[CW+1]) begin
                        rem_next = trial[CW:0];
                        quo_next = {quo_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[CW-1:0], quo_reg[NW-1]};
                        quo_next = {quo_reg[NW-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg - 1'b1;
                end else begin
                    mean_next = neg_reg ? -24'(quo_reg) : 24'(quo_reg);
                    rd_next   = '0;
                    ok_next   = '0;
                end
            end
            ST_CLIP: begin
                // issue read of sample rd; after the last sample, take the kept count and count the pass
                if (rd_reg == n_reg) begin
                    n_next    = ok_reg;
                    pass_next = pass_reg + 1'b1;
                end
            end
            ST_D2: begin
                x_next = $signed(rdata);
                d_next = DW'($signed({1'b0, n_reg})) * DW'($signed(rdata)) - DW'(s_reg);
            end
            ST_CMP: begin
                // keep the sample when its squared deviation is below the threshold
                if (d_sq < thr_reg) begin
                    we      = 1'b1;
                    waddr   = ok_reg[AW-1:0];
                    wdata   = x_reg;
                    ok_next = ok_reg + 1'b1;
                end
                rd_next = rd_reg + 1'b1;
            end
            ST_OUT: begin
                // wait for a free result register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.shift      = mean_reg;
                    m_data_next.kept_count = (n_reg > CW'(255)) ? 8'd255 : 8'(n_reg);
                    fill_next              = '0;
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            mean_reg    <= '0;
            rvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            mean_reg    <= mean_next;
            rvalid_reg  <= rvalid_next;
        end
        n_reg      <= n_next;
        rd_reg     <= rd_next;
        ok_reg     <= ok_next;
        pass_reg   <= pass_next;
        s_reg      <= s_next;
        q_reg      <= q_next;
        v_reg      <= v_next;
        thr_reg    <= thr_next;
        d_reg      <= d_next;
        x_reg      <= x_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // clipping never keeps more samples than it reads
    a_ok_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> ok_reg <= rd_reg)
        else $error("kept count overtook read index");
    // no input beat while a readout is processed
    a_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LOAD |-> !s_ready)
        else $error("input ready outside load");
    // a result is raised only from the output step
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_OUT)
        else $error("result without output step");
    // fill count stays within the store
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(MAX_SAMPLES))
        else $error("fill count overflow");
`endif

endmodule

/* tb/sv/sigma_clipped_common_mode_core_tb.sv */
// Testbench of the sigma-clipped common-mode core: directed and random readouts checked against a predictor.
`timescale 1ns / 1ps

module sigma_clipped_common_mode_core_tb;
    import scm_pkg::*;

    localparam int STORE_DEPTH = 128;

    // Predicts readout results and checks result beats in order
    class shift_scoreboard;
        int          store_q[$];
        int unsigned pass_limit;
        int unsigned clip_sigma;
        scm_out_t    pending[$];
        int          fail_count;

        function void reset_state();
            store_q.delete();
            pending.delete();
            pass_limit = 32'(PASS_LIMIT_RST);
            clip_sigma = 32'(CLIP_SIGMA_RST);
            fail_count = 0;
        endfunction

        function void set_reg(logic idx, logic [3:0] value);
            if (idx == REG_PASS_LIMIT) pass_limit = 32'(value);
            else clip_sigma = 32'(value);
        endfunction

        // Iterated clipping on the stored samples
        function scm_out_t clip_mean();
            scm_out_t    res;
            longint      kept[$];
            longint      nxt[$];
            longint      s, q, v, d, mean;
            longint unsigned thr, d2, c2;
            int unsigned n;
            mean = 0;
            foreach (store_q[i]) kept = {kept, longint'(store_q[i])};
            c2 = 64'(clip_sigma * clip_sigma);
            for (int p = 0; p < pass_limit; p++) begin
                n = kept.size();
                if (n == 0) break;
                s = 0;
                q = 0;
                foreach (kept[i]) begin
                    s += kept[i];
                    q += kept[i] * kept[i];
                end
                mean = (s * 256) / longint'(n);
                v = longint'(n) * q - s * s;
                if (v < 0) v = 0;
                thr = longint'(v) * c2;
                nxt.delete();
                foreach (kept[i]) begin
                    d = longint'(n) * kept[i] - s;
                    d2 = d * d;
                    if (d2 < thr) nxt = {nxt, kept[i]};
                end
                kept = nxt;
            end
            res.shift = mean[23:0];
            res.kept_count = (kept.size() > 255) ? 8'd255 : 8'(kept.size());
            return res;
        endfunction

        function void note_sample(scm_in_t beat);
            if (store_q.size() < STORE_DEPTH) store_q = {store_q, int'(beat.sample)};
            if (beat.last) begin
                pending = {pending, clip_mean()};
                store_q.delete();
            end
        endfunction

        function void check_result(scm_out_t got);
            scm_out_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result beat shift=%0d kept=%0d", got.shift, got.kept_count);
                fail_count++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.shift !== exp_r.shift) begin
                $error("shift: expected %0d, actual %0d", exp_r.shift, got.shift);
                fail_count++;
            end
            if (got.kept_count !== exp_r.kept_count) begin
                $error("kept_count: expected %0d, actual %0d", exp_r.kept_count,
                       got.kept_count);
                fail_count++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    scm_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    scm_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [3:0] cfg_data;

    shift_scoreboard sb;
    int              sink_wait;

    sigma_clipped_common_mode_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Send one sample beat on the channel; valid drops only for a gap
    task automatic send_beat(logic signed [15:0] smp, logic lst, int gap);
        scm_in_t beat;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        beat.sample = smp;
        beat.last = lst;
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(beat);
    endtask

    task automatic write_reg(logic idx, logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for all results, then let a trailing computation drain
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_readout(int len, int mode, bit rnd_gap);
        logic signed [15:0] base;
        logic signed [15:0] v;
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: v = 16'($urandom);
                1: v = base;
                2: v = 16'(base + $signed($urandom_range(0, 16)) - 8);
                default: v = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                             16'(base + $signed($urandom_range(0, 200)) - 100);
            endcase
            send_beat(v, i == len - 1, rnd_gap ? $urandom_range(0, 12) : 0);
        end
    endtask

    // Result side: a random wait before each beat is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= $urandom_range(0, 12);
        end else if (m_valid && m_ready) begin
            sb.check_result(m_data);
            m_ready <= 1'b0;
            sink_wait <= $urandom_range(0, 12);
        end else if (m_valid) begin
            if (sink_wait == 0) m_ready <= 1'b1;
            else sink_wait <= sink_wait - 1;
        end
    end

    initial begin
        int sent;
        int len;
        sb = new();
        sb.reset_state();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PASS_LIMIT;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, single sample, equal samples, outlier
        send_beat(16'sh7fff, 1'b0, 0);
        send_beat(-16'sh8000, 1'b0, 0);
        send_beat(16'sh0000, 1'b1, 0);
        send_beat(16'sh0005, 1'b1, 0);
        for (int i = 0; i < 4; i++) send_beat(-16'sd77, i == 3, 1);
        for (int i = 0; i < 8; i++) send_beat(i == 7 ? 16'sd30000 : 16'(16'sd10 + i), i == 7, 0);
        drain();
        // Zero passes and zero clip threshold
        write_reg(REG_PASS_LIMIT, 4'd0);
        write_reg(REG_CLIP_SIGMA, 4'd0);
        send_beat(16'sd3, 1'b0, 0);
        send_beat(16'sd4, 1'b1, 0);
        drain();
        write_reg(REG_PASS_LIMIT, 4'd1);
        send_beat(16'sd3, 1'b0, 0);
        send_beat(-16'sd9, 1'b1, 0);
        drain();
        // Store overflow, with largest settings
        write_reg(REG_PASS_LIMIT, 4'd15);
        write_reg(REG_CLIP_SIGMA, 4'd15);
        send_readout(STORE_DEPTH + 3, 0, 1'b0);
        drain();
        sent = 0;

        // Random readouts, settings changed between phases
        while (sent < 1100) begin
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_reg(REG_PASS_LIMIT, 4'($urandom_range(0, 15)));
                write_reg(REG_CLIP_SIGMA, 4'($urandom_range(0, 15)));
            end
            len = ($urandom_range(0, 20) == 0) ? $urandom_range(100, 130) :
                  $urandom_range(1, 24);
            send_readout(len, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            sent += len;
        end
        drain();
        if (sb.fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* files.f */
rtl/core/scm_pkg.sv
rtl/core/scm_ram.sv
rtl/core/sigma_clipped_common_mode_core.sv
tb/sv/sigma_clipped_common_mode_core_tb.sv
